[hw/rtl/uv_sphere_vertex_index_generator_assert.svh]
// Assertion macros shared by the UV sphere generator RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef UV_SPHERE_VERTEX_INDEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_VERTEX_INDEX_GENERATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UVS_ASSERT_NOW(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Consequent must hold in the cycle after the antecedent.
`define UVS_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

[hw/rtl/uvs_pkg.sv]
// Shared types and constants of the UV sphere generator.
// No dependencies; imported by the CORDIC and the top level.
`timescale 1ns / 1ps

package uvs_pkg;

  localparam logic [7:0] MAX_SEGMENTS = 8'd255;
  localparam logic [7:0] MIN_SLICES   = 8'd3;
  localparam logic [7:0] MIN_STACKS   = 8'd1;

  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_INDEX  = 1'b1;

  localparam logic [1:0] CFG_SLICES = 2'd0;
  localparam logic [1:0] CFG_STACKS = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  localparam logic [1:0] KIND_VTX   = 2'd0;
  localparam logic [1:0] KIND_TRI_A = 2'd1;
  localparam logic [1:0] KIND_TRI_B = 2'd2;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam logic [31:0] GAIN_Q30 = 32'd652032874;
  localparam logic [31:0] ONE_Q30  = 32'd1073741824;

  typedef struct packed {
    logic [1:0] kind;
    logic       last;
    logic [7:0] stk;
    logic [7:0] sec;
  } uvs_slot_t;

endpackage

[hw/rtl/uv_sphere_vertex_index_generator.sv]
// UV sphere generator top level; uses uvs_pkg, uvs_frac_div, uvs_cordic and the assert header.
// Throughput: one vertex transaction per cycle while busy is low; an index transaction
// that yields two triangles raises busy for a single cycle, so it occupies two issue slots.
// Reset (synchronous, active low) clears all valid bits and restores the registers to
// 32 slices, 16 stacks and radius 1.0; results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module uv_sphere_vertex_index_generator #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [7:0]         in_stack_index,
  input  logic [7:0]         in_sector_index,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [16:0]        out_tex_u,
  output logic [16:0]        out_tex_v,
  output logic [15:0]        out_tri_a,
  output logic [15:0]        out_tri_b,
  output logic [15:0]        out_tri_c,
  output logic               out_last
);
  import uvs_pkg::*;
  `include "uv_sphere_vertex_index_generator_assert.svh"

  // The sector divider produces 32 fraction bits, the stack divider 31; the stack
  // result gets one extra register so both phases reach the CORDICs together.
  localparam int SEC_FRAC = 32;
  localparam int STK_FRAC = 31;
  localparam int DIV_LAT  = SEC_FRAC + 2;
  // Divider, CORDIC (init, iterations, quadrant map), two multiply stages,
  // rounding stage and output register.
  localparam int LAT      = DIV_LAT + CORDIC_STAGES + 6;
  localparam int TEX_DLY  = LAT - 1 - DIV_LAT;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must change them only while the pipeline is empty
  // (not enforced by the block); every stage reads them directly instead of carrying a copy.
  // ---------------------------------------------------------------------------
  logic [7:0]  slices_r;
  logic [7:0]  stacks_r;
  logic [30:0] radius_r;
  logic [7:0]  sl_eff;
  logic [7:0]  st_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slices_r <= 8'd32;
      stacks_r <= 8'd16;
      radius_r <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLICES: slices_r <= cfg_data[7:0];
        CFG_STACKS: stacks_r <= cfg_data[7:0];
        CFG_RADIUS: radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sl_eff = slices_r;
    if (slices_r < MIN_SLICES) sl_eff = MIN_SLICES;
    else if (slices_r > MAX_SEGMENTS) sl_eff = MAX_SEGMENTS;
    st_eff = stacks_r;
    if (stacks_r < MIN_STACKS) st_eff = MIN_STACKS;
    else if (stacks_r > MAX_SEGMENTS) st_eff = MAX_SEGMENTS;
  end

  // ---------------------------------------------------------------------------
  // Issue stage. Each pipeline slot carries at most one result. A vertex
  // transaction takes one slot. An index transaction takes one slot per
  // triangle: the upper triangle of the band unless the stack is the top one,
  // and the lower triangle unless it is the bottom one. When both exist, the
  // second slot is issued in the following cycle while busy is held high.
  // ---------------------------------------------------------------------------
  logic       accept;
  logic [7:0] vi;
  logic [7:0] vj;
  logic [7:0] ti;
  logic [7:0] tj;
  logic       has_a;
  logic       has_b;
  logic       pend_r;
  logic       pend_nxt;
  uvs_slot_t  pend_slot_r;
  uvs_slot_t  pend_slot_nxt;
  logic       vld_nxt;
  uvs_slot_t  slot_nxt;
  logic       vld_r  [0:LAT-1];
  uvs_slot_t  slot_r [0:LAT-1];

  assign busy   = pend_r;
  assign accept = start && !busy;

  assign vi    = (in_stack_index > st_eff) ? st_eff : in_stack_index;
  assign vj    = (in_sector_index > sl_eff) ? sl_eff : in_sector_index;
  assign ti    = (in_stack_index > 8'(st_eff - 8'd1)) ? 8'(st_eff - 8'd1) : in_stack_index;
  assign tj    = (in_sector_index > 8'(sl_eff - 8'd1)) ? 8'(sl_eff - 8'd1)
                                                       : in_sector_index;
  assign has_a = ti != 8'd0;
  assign has_b = ti != 8'(st_eff - 8'd1);

  always_comb begin
    vld_nxt       = 1'b0;
    slot_nxt      = '{kind: KIND_VTX, last: 1'b1, stk: vi, sec: vj};
    pend_nxt      = 1'b0;
    pend_slot_nxt = pend_slot_r;
    if (pend_r) begin
      vld_nxt  = 1'b1;
      slot_nxt = pend_slot_r;
    end else if (accept) begin
      if (in_req_type == REQ_VERTEX) begin
        vld_nxt = 1'b1;
      end else if (has_a) begin
        vld_nxt       = 1'b1;
        slot_nxt      = '{kind: KIND_TRI_A, last: !has_b, stk: ti, sec: tj};
        pend_nxt      = has_b;
        pend_slot_nxt = '{kind: KIND_TRI_B, last: 1'b1, stk: ti, sec: tj};
      end else if (has_b) begin
        vld_nxt  = 1'b1;
        slot_nxt = '{kind: KIND_TRI_B, last: 1'b1, stk: ti, sec: tj};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    slot_r[0]   <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= vld_nxt;
    end
  end

  // Control shift line; the valid bit travels beside the slot's coordinates.
  for (genvar s = 1; s < LAT; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
    end
    always_ff @(posedge clk) begin
      slot_r[s] <= slot_r[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Angle phases and texture coordinates. The sector phase is
  // round(j * 2^32 / slices) modulo one turn; the stack phase is a quarter
  // turn minus round(i * 2^31 / stacks). Both dividers also tap the quotient at
  // 16 fraction bits for the texture coordinates.
  // ---------------------------------------------------------------------------
  logic [SEC_FRAC:0] sec_quo;
  logic [16:0]       sec_tex;
  logic [STK_FRAC:0] stk_quo;
  logic [16:0]       stk_tex;
  logic [STK_FRAC:0] stk_quo_d_r;
  logic [16:0]       stk_tex_d_r;
  logic [31:0]       stk_phase;

  uvs_frac_div #(.FRAC(SEC_FRAC)) u_sec_div (
    .clk (clk),
    .num (slot_r[0].sec),
    .den (sl_eff),
    .quo (sec_quo),
    .tex (sec_tex)
  );

  uvs_frac_div #(.FRAC(STK_FRAC)) u_stk_div (
    .clk (clk),
    .num (slot_r[0].stk),
    .den (st_eff),
    .quo (stk_quo),
    .tex (stk_tex)
  );

  always_ff @(posedge clk) begin
    stk_quo_d_r <= stk_quo;
    stk_tex_d_r <= stk_tex;
  end

  assign stk_phase = ONE_Q30 - stk_quo_d_r[31:0];

  logic [16:0] texu_d_r [0:TEX_DLY-1];
  logic [16:0] texv_d_r [0:TEX_DLY-1];

  always_ff @(posedge clk) begin
    texu_d_r[0] <= 17'd65536 - sec_tex;
    texv_d_r[0] <= stk_tex_d_r;
  end

  for (genvar s = 1; s < TEX_DLY; s++) begin : g_tex
    always_ff @(posedge clk) begin
      texu_d_r[s] <= texu_d_r[s-1];
      texv_d_r[s] <= texv_d_r[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Sine and cosine of both angles.
  // ---------------------------------------------------------------------------
  logic signed [31:0] cs;
  logic signed [31:0] ss;
  logic signed [31:0] cp;
  logic signed [31:0] sp;

  uvs_cordic #(.STAGES(CORDIC_STAGES)) u_stk_cordic (
    .clk   (clk),
    .phase (stk_phase),
    .cos_o (cs),
    .sin_o (ss)
  );

  uvs_cordic #(.STAGES(CORDIC_STAGES)) u_sec_cordic (
    .clk   (clk),
    .phase (sec_quo[31:0]),
    .cos_o (cp),
    .sin_o (sp)
  );

  // ---------------------------------------------------------------------------
  // Direction vector: dx = cos s * cos t, dy = sin s, dz = cos s * sin t, each
  // product rounded half up back to Q30.
  // ---------------------------------------------------------------------------
  logic signed [63:0] px_r;
  logic signed [63:0] pz_r;
  logic signed [31:0] dy1_r;
  logic signed [63:0] px_rnd;
  logic signed [63:0] pz_rnd;
  logic signed [31:0] dx_r;
  logic signed [31:0] dy_r;
  logic signed [31:0] dz_r;

  always_ff @(posedge clk) begin
    px_r  <= cs * cp;
    pz_r  <= cs * sp;
    dy1_r <= ss;
  end

  assign px_rnd = px_r + 64'sh2000_0000;
  assign pz_rnd = pz_r + 64'sh2000_0000;

  always_ff @(posedge clk) begin
    dx_r <= px_rnd[61:30];
    dy_r <= dy1_r;
    dz_r <= pz_rnd[61:30];
  end

  // ---------------------------------------------------------------------------
  // Position products and normals. The normal is the direction rounded from
  // Q30 to Q14 and clamped to plus or minus one.
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] norm_q14(input logic signed [31:0] d);
    logic signed [32:0] t;
    logic signed [16:0] n;
    t = {d[31], d} + 33'sd32768;
    n = t[32:16];
    if (n > 17'sd16384) return 16'sd16384;
    if (n < -17'sd16384) return -16'sd16384;
    return n[15:0];
  endfunction

  // Position: rounded half up from the Q46 product, saturated to 32 bits.
  function automatic logic signed [31:0] pos_q16(input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [33:0] v;
    t = p + 64'sh2000_0000;
    v = t[63:30];
    if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  logic signed [31:0] rad_s;
  logic signed [63:0] ppx_r;
  logic signed [63:0] ppy_r;
  logic signed [63:0] ppz_r;
  logic signed [15:0] nx_r;
  logic signed [15:0] ny_r;
  logic signed [15:0] nz_r;

  assign rad_s = signed'({1'b0, radius_r});

  always_ff @(posedge clk) begin
    ppx_r <= rad_s * dx_r;
    ppy_r <= rad_s * dy_r;
    ppz_r <= rad_s * dz_r;
    nx_r  <= norm_q14(dx_r);
    ny_r  <= norm_q14(dy_r);
    nz_r  <= norm_q14(dz_r);
  end

  // ---------------------------------------------------------------------------
  // Output register. Triangle indices are formed here from the slot's
  // coordinates: k1 = i * (slices + 1) + j and k2 = k1 + slices + 1.
  // ---------------------------------------------------------------------------
  uvs_slot_t   slot_end;
  logic [8:0]  sl1;
  logic [16:0] k1;
  logic [16:0] k2;

  assign slot_end = slot_r[LAT-1];
  assign sl1      = {1'b0, sl_eff} + 9'd1;
  assign k1       = ({9'd0, slot_end.stk} * {8'd0, sl1}) + {9'd0, slot_end.sec};
  assign k2       = k1 + {8'd0, sl1};

  logic               out_valid_r;
  logic signed [31:0] out_pos_x_r;
  logic signed [31:0] out_pos_y_r;
  logic signed [31:0] out_pos_z_r;
  logic signed [15:0] out_norm_x_r;
  logic signed [15:0] out_norm_y_r;
  logic signed [15:0] out_norm_z_r;
  logic [16:0]        out_tex_u_r;
  logic [16:0]        out_tex_v_r;
  logic [15:0]        out_tri_a_r;
  logic [15:0]        out_tri_b_r;
  logic [15:0]        out_tri_c_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_last_r   <= slot_end.last;
    out_pos_x_r  <= '0;
    out_pos_y_r  <= '0;
    out_pos_z_r  <= '0;
    out_norm_x_r <= '0;
    out_norm_y_r <= '0;
    out_norm_z_r <= '0;
    out_tex_u_r  <= '0;
    out_tex_v_r  <= '0;
    out_tri_a_r  <= '0;
    out_tri_b_r  <= '0;
    out_tri_c_r  <= '0;
    case (slot_end.kind)
      KIND_VTX: begin
        out_pos_x_r  <= pos_q16(ppx_r);
        out_pos_y_r  <= pos_q16(ppy_r);
        out_pos_z_r  <= pos_q16(ppz_r);
        out_norm_x_r <= nx_r;
        out_norm_y_r <= ny_r;
        out_norm_z_r <= nz_r;
        out_tex_u_r  <= texu_d_r[TEX_DLY-1];
        out_tex_v_r  <= texv_d_r[TEX_DLY-1];
      end
      KIND_TRI_A: begin
        out_tri_a_r <= k1[15:0];
        out_tri_b_r <= k2[15:0];
        out_tri_c_r <= 16'(k1 + 17'd1);
      end
      KIND_TRI_B: begin
        out_tri_a_r <= 16'(k1 + 17'd1);
        out_tri_b_r <= k2[15:0];
        out_tri_c_r <= 16'(k2 + 17'd1);
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_pos_x  = out_pos_x_r;
  assign out_pos_y  = out_pos_y_r;
  assign out_pos_z  = out_pos_z_r;
  assign out_norm_x = out_norm_x_r;
  assign out_norm_y = out_norm_y_r;
  assign out_norm_z = out_norm_z_r;
  assign out_tex_u  = out_tex_u_r;
  assign out_tex_v  = out_tex_v_r;
  assign out_tri_a  = out_tri_a_r;
  assign out_tri_b  = out_tri_b_r;
  assign out_tri_c  = out_tri_c_r;
  assign out_last   = out_last_r;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `UVS_ASSERT_NEXT(a_second_tri_holds_busy, clk, rst_n,
    accept && (in_req_type == REQ_INDEX) && has_a && has_b, busy,
    "index transaction with two triangles did not raise busy")
  `UVS_ASSERT_NEXT(a_busy_single_cycle, clk, rst_n, busy, !busy,
    "busy held for more than one cycle")
  `UVS_ASSERT_NEXT(a_vertex_is_last, clk, rst_n,
    vld_r[LAT-1] && (slot_end.kind == KIND_VTX), out_valid && out_last,
    "vertex result not marked last")
  `UVS_ASSERT_NOW(a_norm_range, clk, rst_n, out_valid,
    (out_norm_y >= -16'sd16384) && (out_norm_y <= 16'sd16384),
    "normal component outside unit range")

endmodule

[hw/rtl/uvs_frac_div.sv]
// Pipelined fractional divider: round(num * 2^FRAC / den) and round(num * 2^16 / den).
// Depends on nothing but its ports; one quotient bit per stage.
`timescale 1ns / 1ps

module uvs_frac_div #(
  parameter int FRAC = 32
) (
  input  logic            clk,
  input  logic [7:0]      num,
  input  logic [7:0]      den,
  output logic [FRAC:0]   quo,
  output logic [16:0]     tex
);

  logic [FRAC:0] q_r   [0:FRAC];
  logic [7:0]    r_r   [0:FRAC];
  logic [16:0]   tex_r [17:FRAC];
  logic [FRAC:0] quo_r;
  logic [16:0]   tex_out_r;
  logic [7:0]    half;
  logic          carry_tex;
  logic          carry_end;

  assign half      = den >> 1;
  assign carry_tex = ({1'b0, r_r[16]} + {1'b0, half}) >= {1'b0, den};
  assign carry_end = ({1'b0, r_r[FRAC]} + {1'b0, half}) >= {1'b0, den};

  // Integer step: the numerator never exceeds the divisor.
  always_ff @(posedge clk) begin
    q_r[0] <= {{FRAC{1'b0}}, (num >= den)};
    r_r[0] <= (num >= den) ? 8'(num - den) : num;
  end

  for (genvar s = 1; s <= FRAC; s++) begin : g_step
    logic [8:0] t;
    logic       qb;
    assign t  = {r_r[s-1], 1'b0};
    assign qb = t >= {1'b0, den};
    always_ff @(posedge clk) begin
      q_r[s] <= {q_r[s-1][FRAC-1:0], qb};
      r_r[s] <= qb ? 8'(t - {1'b0, den}) : t[7:0];
    end
  end

  always_ff @(posedge clk) begin
    tex_r[17] <= q_r[16][16:0] + {16'd0, carry_tex};
  end

  for (genvar s = 18; s <= FRAC; s++) begin : g_tex
    always_ff @(posedge clk) begin
      tex_r[s] <= tex_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= q_r[FRAC] + {{FRAC{1'b0}}, carry_end};
    tex_out_r <= tex_r[FRAC];
  end

  assign quo = quo_r;
  assign tex = tex_out_r;

endmodule

[hw/rtl/uvs_cordic.sv]
// Pipelined rotation CORDIC giving cosine and sine of a 32-bit turn phase in Q30.
// Depends on uvs_pkg for the arctangent table, gain and quadrant codes.
`timescale 1ns / 1ps

module uvs_cordic #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic [31:0]        phase,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import uvs_pkg::*;

  localparam int W  = 34;
  localparam int ZW = 33;

  logic signed [W-1:0]  x_r [0:STAGES];
  logic signed [W-1:0]  y_r [0:STAGES];
  logic signed [ZW-1:0] z_r [0:STAGES];
  logic [1:0]           q_r [0:STAGES];
  logic signed [31:0]   cos_r;
  logic signed [31:0]   sin_r;
  logic signed [31:0]   xf;
  logic signed [31:0]   yf;

  always_ff @(posedge clk) begin
    x_r[0] <= {2'b00, GAIN_Q30};
    y_r[0] <= '0;
    z_r[0] <= {3'b000, phase[29:0]};
    q_r[0] <= phase[31:30];
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_iter
    logic signed [W-1:0]  sx;
    logic signed [W-1:0]  sy;
    logic signed [ZW-1:0] at;
    logic                 rot_pos;
    assign sx      = y_r[k] >>> k;
    assign sy      = x_r[k] >>> k;
    assign at      = signed'({1'b0, ATAN_TURNS[k]});
    assign rot_pos = !z_r[k][ZW-1];
    always_ff @(posedge clk) begin
      x_r[k+1] <= rot_pos ? x_r[k] - sx : x_r[k] + sx;
      y_r[k+1] <= rot_pos ? y_r[k] + sy : y_r[k] - sy;
      z_r[k+1] <= rot_pos ? z_r[k] - at : z_r[k] + at;
      q_r[k+1] <= q_r[k];
    end
  end

  assign xf = x_r[STAGES][31:0];
  assign yf = y_r[STAGES][31:0];

  always_ff @(posedge clk) begin
    case (q_r[STAGES])
      QUAD_0: begin
        cos_r <= xf;
        sin_r <= yf;
      end
      QUAD_1: begin
        cos_r <= -yf;
        sin_r <= xf;
      end
      QUAD_2: begin
        cos_r <= -xf;
        sin_r <= -yf;
      end
      QUAD_3: begin
        cos_r <= yf;
        sin_r <= -xf;
      end
      default: begin
        cos_r <= xf;
        sin_r <= yf;
      end
    endcase
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
